>>> src/drm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the dirty rectangle merge table.
package drm_pkg;

   typedef logic signed [15:0] coord_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
   } rect_type;

   typedef enum logic [1:0] {
      ACT_MERGED   = 2'd0,
      ACT_STORED   = 2'd1,
      ACT_PAIRED   = 2'd2,
      ACT_REJECTED = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PAIR,
      ST_FINISH,
      ST_OUT
   } state_type;

   localparam logic [0:0] REG_X_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_Y_THRESHOLD = 1'b1;

   // Slot is in use when both width and height are nonzero.
   function automatic logic rect_used(rect_type s);
      return (s.r != s.l) && (s.b != s.t);
   endfunction

   function automatic logic rect_void(rect_type s);
      return (s.r <= s.l) || (s.b <= s.t);
   endfunction

   function automatic logic rect_near(rect_type s, rect_type n,
                                      logic [11:0] gx, logic [11:0] gy);
      logic signed [17:0] gxs;
      logic signed [17:0] gys;
      gxs = signed'({6'd0, gx});
      gys = signed'({6'd0, gy});
      return !((18'(s.r) < 18'(n.l) - gxs) || (18'(s.l) > 18'(n.r) + gxs) ||
               (18'(s.b) < 18'(n.t) - gys) || (18'(s.t) > 18'(n.b) + gys));
   endfunction

   function automatic rect_type rect_union(rect_type a, rect_type b);
      rect_type d;
      if (rect_void(a)) begin
         d = b;
      end else if (rect_void(b)) begin
         d = a;
      end else begin
         d.l = (a.l < b.l) ? a.l : b.l;
         d.t = (a.t < b.t) ? a.t : b.t;
         d.r = (a.r > b.r) ? a.r : b.r;
         d.b = (a.b > b.b) ? a.b : b.b;
      end
      return d;
   endfunction

endpackage

>>> src/drm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
interface drm_req_if;
   logic             valid;
   logic             ready;
   drm_pkg::coord_type new_left;
   drm_pkg::coord_type new_top;
   drm_pkg::coord_type new_right;
   drm_pkg::coord_type new_bottom;
   modport source (output valid, new_left, new_top, new_right, new_bottom, input ready);
   modport sink (input valid, new_left, new_top, new_right, new_bottom, output ready);
endinterface

interface drm_rsp_if;
   logic             valid;
   logic             ready;
   logic             accepted;
   logic [1:0]       action;
   logic [3:0]       slot;
   logic [3:0]       absorbing_slot;
   drm_pkg::coord_type out_left;
   drm_pkg::coord_type out_top;
   drm_pkg::coord_type out_right;
   drm_pkg::coord_type out_bottom;
   modport source (output valid, accepted, action, slot, absorbing_slot,
                   out_left, out_top, out_right, out_bottom, input ready);
   modport sink (input valid, accepted, action, slot, absorbing_slot,
                 out_left, out_top, out_right, out_bottom, output ready);
endinterface

>>> src/drm_cell.sv
`timescale 1ns / 1ps
// One slot cell of the rotating slot ring.
module drm_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              load,
   input  drm_pkg::rect_type load_rect,
   input  drm_pkg::rect_type prev_rect,
   output drm_pkg::rect_type rect
);
   import drm_pkg::*;

   rect_type rect_ff;
   rect_type rect_in;

   always_comb begin
      rect_in = rect_ff;
      if (load) begin
         rect_in = load_rect;
      end else if (shift) begin
         rect_in = prev_rect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_ff <= '0;
      end else begin
         rect_ff <= rect_in;
      end
   end

   assign rect = rect_ff;
endmodule

>>> src/dirty_rect_merge_table.sv
`timescale 1ns / 1ps
// Dirty rectangle merge table: top level with controller and slot ring.
// The slots form a ring of cells that rotates one place per cycle past a
// single compare point at cell 0, and a slot is rewritten as it wraps from
// cell 0 into the last cell. A request takes one pass of the ring for
// the merge and empty-slot scan. Storing into an empty slot adds one more pass
// to reach that slot. When the table is full, the pair search takes one pass
// per candidate first slot, up to SLOT_COUNT - 1 passes, and a found pair adds
// one pass to write the union back. The result is then presented until it is
// taken, and the table returns to idle. The ring rotation sets the rate while
// a request is worked: one slot compare per cycle. The ring holds otherwise.
module dirty_rect_merge_table #(
   parameter int SLOT_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   drm_req_if.sink          req,
   drm_rsp_if.source        rsp,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import drm_pkg::*;

   localparam int IW = $clog2(SLOT_COUNT);

   logic [11:0] xth_ff, yth_ff;
   state_type   state_ff, state_in;
   rect_type    new_ff, new_in;
   rect_type    hold_ff, hold_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] base_ff, base_in;
   logic        found_ff, found_in;
   logic        blank_ff, blank_in;
   logic [1:0]  act_ff, act_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [IW-1:0] abs_ff, abs_in;
   rect_type    res_ff, res_in;

   rect_type cells [SLOT_COUNT];
   logic     shift;
   logic     tail_load;
   rect_type tail_rect;

   genvar g;
   generate
      for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
         logic     ld;
         rect_type lr;
         if (g == SLOT_COUNT - 1) begin : g_tail
            assign ld = tail_load;
            assign lr = tail_rect;
         end else begin : g_rest
            assign ld = 1'b0;
            assign lr = '0;
         end
         drm_cell u_cell (
            .clock(clock), .reset(reset), .shift(shift), .load(ld), .load_rect(lr),
            .prev_rect(cells[(g + 1) % SLOT_COUNT]), .rect(cells[g])
         );
      end
   endgenerate

   // Cell 0 holds logical slot pos_ff; rotating moves slot pos_ff+1 in.
   logic [IW-1:0] last;
   logic [IW-1:0] pos_next;
   assign last = IW'(SLOT_COUNT - 1);
   assign pos_next = (pos_ff == last) ? '0 : pos_ff + IW'(1);

   logic near_in, near_pair;
   logic merge_hit, pair_hit;
   rect_type uni_in, uni_pair;
   assign near_in   = rect_near(cells[0], new_ff, xth_ff, yth_ff);
   assign uni_in    = rect_union(cells[0], new_ff);
   assign near_pair = rect_near(hold_ff, cells[0], 12'd0, 12'd0);
   assign uni_pair  = rect_union(hold_ff, cells[0]);
   assign merge_hit = rect_used(cells[0]) && near_in
                      && !(rect_void(cells[0]) && rect_void(new_ff));
   assign pair_hit  = (pos_ff > base_ff) && rect_used(hold_ff) && rect_used(cells[0])
                      && near_pair && !(rect_void(hold_ff) && rect_void(cells[0]));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req.valid) state_in = ST_SCAN;
         ST_SCAN: begin
            if (pos_ff == last) begin
               if (found_ff || merge_hit) state_in = ST_OUT;
               else if (blank_ff || !rect_used(cells[0])) state_in = ST_FINISH;
               else state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (pos_ff == last) begin
               if (found_ff || pair_hit) state_in = ST_FINISH;
               else if (base_ff == last - IW'(1)) state_in = ST_OUT;
            end
         end
         ST_FINISH: if (pos_ff == last) state_in = ST_OUT;
         ST_OUT:    if (rsp.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      new_in = new_ff; hold_in = hold_ff; pos_in = pos_ff; base_in = base_ff;
      found_in = found_ff; blank_in = blank_ff; act_in = act_ff; slot_in = slot_ff;
      abs_in = abs_ff; res_in = res_ff;
      shift = 1'b0; tail_load = 1'b0; tail_rect = '0;
      unique case (state_ff)
         ST_IDLE: begin
            new_in.l = req.new_left;  new_in.t = req.new_top;
            new_in.r = req.new_right; new_in.b = req.new_bottom;
            found_in = 1'b0; blank_in = 1'b0;
            act_in = ACT_REJECTED; slot_in = '0; abs_in = '0; res_in = '0;
            base_in = '0;
         end
         ST_SCAN: begin
            shift = 1'b1; pos_in = pos_next;
            if (!found_ff && merge_hit) begin
               tail_load = 1'b1; tail_rect = uni_in; found_in = 1'b1;
               act_in = ACT_MERGED; slot_in = pos_ff; res_in = uni_in;
            end else if (!found_ff && !blank_ff && !rect_used(cells[0])) begin
               blank_in = 1'b1; slot_in = pos_ff;
            end
            if (pos_ff == last && !found_ff && !merge_hit
                && (blank_ff || !rect_used(cells[0]))) begin
               found_in = 1'b1; act_in = ACT_STORED; res_in = new_ff;
            end
         end
         ST_PAIR: begin
            // The pass captures slot base into hold, then compares the later slots.
            shift = 1'b1; pos_in = pos_next;
            if (!found_ff) begin
               if (pos_ff == base_ff) begin
                  hold_in = cells[0];
               end else if (pair_hit) begin
                  tail_load = 1'b1; tail_rect = new_ff; hold_in = uni_pair;
                  found_in = 1'b1; act_in = ACT_PAIRED;
                  slot_in = pos_ff; abs_in = base_ff; res_in = new_ff;
               end else if (pos_ff == last && base_ff != last - IW'(1)) begin
                  base_in = base_ff + IW'(1);
               end
            end
         end
         ST_FINISH: begin
            shift = 1'b1; pos_in = pos_next;
            if (act_ff == ACT_PAIRED && pos_ff == abs_ff) begin
               tail_load = 1'b1; tail_rect = hold_ff;
            end else if (act_ff == ACT_STORED && pos_ff == slot_ff) begin
               tail_load = 1'b1; tail_rect = new_ff;
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pos_ff <= '0; base_ff <= '0;
         found_ff <= 1'b0; blank_ff <= 1'b0;
         xth_ff <= '0; yth_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in; base_ff <= base_in; found_ff <= found_in;
         blank_ff <= blank_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_X_THRESHOLD, 2'b00}) xth_ff <= csr_pwdata[11:0];
            else if (csr_paddr == {REG_Y_THRESHOLD, 2'b00}) yth_ff <= csr_pwdata[11:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      new_ff <= new_in; hold_ff <= hold_in;
      act_ff <= act_in; slot_ff <= slot_in; abs_ff <= abs_in; res_ff <= res_in;
   end

   assign req.ready  = (state_ff == ST_IDLE);
   assign rsp.valid  = (state_ff == ST_OUT);
   assign rsp.accepted = found_ff;
   assign rsp.action = act_ff;
   assign rsp.slot   = 4'(slot_ff);
   assign rsp.absorbing_slot = 4'(abs_ff);
   assign rsp.out_left = res_ff.l;   assign rsp.out_top = res_ff.t;
   assign rsp.out_right = res_ff.r;  assign rsp.out_bottom = res_ff.b;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == {REG_Y_THRESHOLD, 2'b00}) ? {20'd0, yth_ff} :
                       (csr_paddr == {REG_X_THRESHOLD, 2'b00}) ? {20'd0, xth_ff} : 32'd0;
endmodule

>>> src/drm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the dirty rectangle merge table.
module drm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic [1:0] rsp_action
);
   import drm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_acc_act: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_action != ACT_REJECTED)))
      else $error("accepted and action disagree");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result waits");
   a_req_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request");
endmodule

bind dirty_rect_merge_table drm_checker u_drm_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_accepted(rsp.accepted),
   .rsp_action(rsp.action)
);

>>> tb/sv/dirty_rect_merge_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the dirty rectangle merge table with its own table model.
module dirty_rect_merge_table_tb;
   import drm_pkg::*;

   typedef struct {
      int l;
      int t;
      int r;
      int b;
   } box_type;

   typedef struct {
      logic       accepted;
      action_type action;
      logic [3:0] slot;
      logic [3:0] absorbing_slot;
      coord_type  l;
      coord_type  t;
      coord_type  r;
      coord_type  b;
   } outcome_type;

   localparam int TABLE_SIZE = 16;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   drm_req_if req ();
   drm_rsp_if rsp ();

   dirty_rect_merge_table #(.SLOT_COUNT(TABLE_SIZE)) dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   box_type dirty_table [TABLE_SIZE];
   logic [11:0] gap_x;
   logic [11:0] gap_y;
   rect_type pending_rects [$];
   outcome_type awaited [$];
   rect_type cur_rect;
   int send_wait;
   int stall_wait;
   bit quiet_send;
   bit quiet_recv;
   int fail_count;
   int cycle_count;
   int sent_count;
   int result_count;
   int action_seen [4];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit box_used(box_type s);
      return s.r != s.l && s.b != s.t;
   endfunction

   function automatic bit box_void(box_type s);
      return s.r <= s.l || s.b <= s.t;
   endfunction

   function automatic bit box_near(box_type s, box_type n, int gx, int gy);
      return !(s.r < n.l - gx || s.l > n.r + gx || s.b < n.t - gy || s.t > n.b + gy);
   endfunction

   function automatic bit box_join(box_type a, box_type b, output box_type d);
      d = a;
      if (box_void(a) && box_void(b)) return 1'b0;
      if (box_void(a)) begin
         d = b;
      end else if (!box_void(b)) begin
         d.l = a.l < b.l ? a.l : b.l;
         d.t = a.t < b.t ? a.t : b.t;
         d.r = a.r > b.r ? a.r : b.r;
         d.b = a.b > b.b ? a.b : b.b;
      end
      return 1'b1;
   endfunction

   function automatic outcome_type merge_into_table(rect_type in_rect);
      box_type n;
      box_type u;
      box_type res;
      outcome_type o;
      bit done;
      bit have_blank;
      int blank;
      n.l = in_rect.l;
      n.t = in_rect.t;
      n.r = in_rect.r;
      n.b = in_rect.b;
      res = '{0, 0, 0, 0};
      done = 1'b0;
      have_blank = 1'b0;
      blank = 0;
      o.accepted = 1'b0;
      o.action = ACT_REJECTED;
      o.slot = '0;
      o.absorbing_slot = '0;
      for (int i = 0; i < TABLE_SIZE && !done; i++) begin
         if (box_used(dirty_table[i])) begin
            if (box_near(dirty_table[i], n, int'(gap_x), int'(gap_y)) &&
                box_join(dirty_table[i], n, u)) begin
               dirty_table[i] = u;
               o.action = ACT_MERGED;
               o.slot = i[3:0];
               res = u;
               done = 1'b1;
            end
         end else if (!have_blank) begin
            have_blank = 1'b1;
            blank = i;
         end
      end
      if (!done && have_blank) begin
         dirty_table[blank] = n;
         o.action = ACT_STORED;
         o.slot = blank[3:0];
         res = n;
         done = 1'b1;
      end
      for (int i = 0; i < TABLE_SIZE && !done; i++) begin
         for (int c = i + 1; c < TABLE_SIZE && !done; c++) begin
            if (box_used(dirty_table[i]) && box_used(dirty_table[c]) &&
                box_near(dirty_table[i], dirty_table[c], 0, 0) &&
                box_join(dirty_table[i], dirty_table[c], u)) begin
               dirty_table[i] = u;
               dirty_table[c] = n;
               o.action = ACT_PAIRED;
               o.slot = c[3:0];
               o.absorbing_slot = i[3:0];
               res = n;
               done = 1'b1;
            end
         end
      end
      o.accepted = done;
      o.l = coord_type'(res.l);
      o.t = coord_type'(res.t);
      o.r = coord_type'(res.r);
      o.b = coord_type'(res.b);
      return o;
   endfunction

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 14));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.new_left <= '0;
         req.new_top <= '0;
         req.new_right <= '0;
         req.new_bottom <= '0;
         send_wait <= 0;
         quiet_send <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            awaited.push_back(merge_into_table(cur_rect));
            sent_count++;
         end
         if (!(req.valid && !req.ready)) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req.valid <= 1'b0;
            end else if (pending_rects.size() > 0) begin
               cur_rect = pending_rects.pop_front();
               req.new_left <= cur_rect.l;
               req.new_top <= cur_rect.t;
               req.new_right <= cur_rect.r;
               req.new_bottom <= cur_rect.b;
               req.valid <= 1'b1;
               if ($urandom_range(0, 40) == 0) quiet_send <= !quiet_send;
               send_wait <= draw_wait(quiet_send);
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      int w;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_wait <= 0;
         quiet_recv <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         result_count++;
         if (awaited.size() == 0) begin
            $error("result arrived with no request outstanding");
            fail_count++;
         end else begin
            e = awaited.pop_front();
            action_seen[e.action]++;
            if (rsp.accepted !== e.accepted) begin
               $error("accepted: expected %0d, got %0d", e.accepted, rsp.accepted);
               fail_count++;
            end
            if (rsp.action !== e.action) begin
               $error("action: expected %0d, got %0d", e.action, rsp.action);
               fail_count++;
            end
            if (rsp.slot !== e.slot) begin
               $error("slot: expected %0d, got %0d", e.slot, rsp.slot);
               fail_count++;
            end
            if (rsp.absorbing_slot !== e.absorbing_slot) begin
               $error("absorbing_slot: expected %0d, got %0d", e.absorbing_slot,
                      rsp.absorbing_slot);
               fail_count++;
            end
            if (rsp.out_left !== e.l) begin
               $error("out_left: expected %0d, got %0d", e.l, rsp.out_left);
               fail_count++;
            end
            if (rsp.out_top !== e.t) begin
               $error("out_top: expected %0d, got %0d", e.t, rsp.out_top);
               fail_count++;
            end
            if (rsp.out_right !== e.r) begin
               $error("out_right: expected %0d, got %0d", e.r, rsp.out_right);
               fail_count++;
            end
            if (rsp.out_bottom !== e.b) begin
               $error("out_bottom: expected %0d, got %0d", e.b, rsp.out_bottom);
               fail_count++;
            end
         end
         if ($urandom_range(0, 30) == 0) quiet_recv <= !quiet_recv;
         w = draw_wait(quiet_recv);
         stall_wait <= w;
         rsp.ready <= (w == 0);
      end else if (stall_wait > 1) begin
         stall_wait <= stall_wait - 1;
         rsp.ready <= 1'b0;
      end else begin
         stall_wait <= 0;
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dirty_rect_merge_table_tb NOT OK");
         $finish;
      end
   end

   task automatic write_threshold(logic [0:0] index, logic [11:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {20'($urandom_range(0, 1048575)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_X_THRESHOLD) gap_x = value;
      else gap_y = value;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_rects.size() > 0 || req.valid || awaited.size() > 0) @(negedge clock);
   endtask

   task automatic add_rect(int l, int t, int r, int b);
      rect_type x;
      x.l = coord_type'(l);
      x.t = coord_type'(t);
      x.r = coord_type'(r);
      x.b = coord_type'(b);
      pending_rects.push_back(x);
   endtask

   task automatic add_random_rect();
      int kind;
      int x0;
      int y0;
      int zone;
      rect_type x;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         zone = $urandom_range(0, 39);
         x0 = -32000 + (zone % 8) * 8000 + $urandom_range(0, 300);
         y0 = -32000 + (zone / 8) * 12000 + $urandom_range(0, 300);
         add_rect(x0, y0, x0 + $urandom_range(1, 400), y0 + $urandom_range(1, 400));
      end else if (kind < 75) begin
         x[31:0] = $urandom;
         x[63:32] = $urandom;
         pending_rects.push_back(x);
      end else if (kind < 85) begin
         x0 = $urandom_range(0, 2000) - 1000;
         y0 = $urandom_range(0, 2000) - 1000;
         if ($urandom_range(0, 1)) add_rect(x0, y0, x0, y0 + $urandom_range(0, 50));
         else add_rect(x0, y0, x0 - $urandom_range(1, 50), y0 - $urandom_range(0, 50));
      end else begin
         x0 = $urandom_range(0, 2000) - 1000;
         y0 = $urandom_range(0, 2000) - 1000;
         add_rect(x0, y0, x0 + $urandom_range(1, 60), y0 + $urandom_range(1, 60));
      end
   endtask

   initial begin
      logic [11:0] settings [6][2];
      settings = '{'{12'd0, 12'd0}, '{12'd4095, 12'd0}, '{12'd0, 12'd4095},
                   '{12'd3, 12'd7}, '{12'd4095, 12'd4095}, '{12'd0, 12'd0}};
      for (int i = 0; i < TABLE_SIZE; i++) dirty_table[i] = '{0, 0, 0, 0};
      gap_x = '0;
      gap_y = '0;
      fail_count = 0;
      cycle_count = 0;
      sent_count = 0;
      result_count = 0;
      action_seen = '{0, 0, 0, 0};
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_rect(0, 0, 10, 10);
      add_rect(10, 0, 20, 10);
      add_rect(5, 5, 5, 5);
      add_rect(20, 20, 10, 10);
      add_rect(30, 30, 30, 30);
      add_rect(15, 15, 15, 40);
      for (int k = 0; k < 15; k++) add_rect(-30000 + k * 4000, -30000,
                                             -29900 + k * 4000, -29900);
      add_rect(30000, 30000, 30100, 30100);
      add_rect(-32768, -32768, 32767, 32767);
      add_rect(32767, 32767, -32768, -32768);
      add_rect(-32768, 32767, 32767, -32768);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_threshold(REG_X_THRESHOLD, settings[p][0]);
         write_threshold(REG_Y_THRESHOLD, settings[p][1]);
         for (int k = 0; k < 88; k++) add_random_rect();
         drain();
      end
      repeat (300) @(posedge clock);

      $display("Sent %0d rectangles over 6 threshold settings; %0d results checked.",
               sent_count, result_count);
      $display("Merged %0d, stored %0d, pair-merged %0d, rejected %0d.",
               action_seen[ACT_MERGED], action_seen[ACT_STORED],
               action_seen[ACT_PAIRED], action_seen[ACT_REJECTED]);
      if (fail_count == 0 && awaited.size() == 0) begin
         $display("dirty_rect_merge_table_tb OK");
      end else begin
         $display("dirty_rect_merge_table_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> dirty_rect_merge_table.f
src/drm_pkg.sv
src/drm_if.sv
src/drm_cell.sv
src/dirty_rect_merge_table.sv
src/drm_checker.sv
tb/sv/dirty_rect_merge_table_tb.sv
